[rtl/core/mcd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mcd_pkg
// Shared types, codes and sizing constants of the MESI coherence directory.
// ----------------------------------------------------------------------------
package mcd_pkg;

   // Directory sizing. LINES and LINE_BYTES are powers of two.
   localparam int LINES      = 1024;
   localparam int LINE_BYTES = 64;
   localparam int HOSTS      = 64;

   localparam int IDX_W     = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int OFF_W     = $clog2(LINE_BYTES);
   localparam int HOST_W    = 6;
   localparam int SHARER_W  = 64;
   localparam int EPOCH_W   = 32;
   localparam int COUNT_W   = 32;
   localparam int NUM_KINDS = 5;

   typedef enum logic [1:0] {
      ST_I = 2'd0,
      ST_S = 2'd1,
      ST_E = 2'd2,
      ST_M = 2'd3
   } mesi_state_type;

   typedef enum logic [2:0] {
      KIND_READ_SHARED = 3'd0,
      KIND_READ_MODIFY = 3'd1,
      KIND_UPGRADE     = 3'd2,
      KIND_DROP_SHARED = 3'd3,
      KIND_WRITE_BACK  = 3'd4
   } req_kind_type;

   typedef enum logic [2:0] {
      STATUS_COMMIT    = 3'd0,
      STATUS_NO_CHANGE = 3'd1,
      STATUS_BAD_STATE = 3'd2,
      STATUS_BAD_HOST  = 3'd3,
      STATUS_UNALIGNED = 3'd4
   } status_type;

   typedef struct packed {
      mesi_state_type         state;
      logic [HOST_W-1:0]      owner;
      logic [SHARER_W-1:0]    sharers;
      logic [EPOCH_W-1:0]     epoch;
      logic                   mem_current;
   } dir_entry_type;

   typedef struct packed {
      status_type    status;
      dir_entry_type snapshot;
      logic          commit;
   } upd_result_type;

   localparam dir_entry_type DIR_IDLE = '{
      state:       ST_I,
      owner:       '0,
      sharers:     '0,
      epoch:       '0,
      mem_current: 1'b1
   };

endpackage
`default_nettype wire

[rtl/core/mcd_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mcd_req_if
// Request channel: kind, line byte address and requesting host.
// ----------------------------------------------------------------------------
interface mcd_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [15:0] req_addr;
   logic [7:0]  requester;

   modport source (output valid, output req_type, output req_addr,
                   output requester, input ready);
   modport sink   (input valid, input req_type, input req_addr,
                   input requester, output ready);
endinterface
`default_nettype wire

[rtl/core/mcd_rsp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mcd_rsp_if
// Response channel: status and snapshot of the addressed line.
// ----------------------------------------------------------------------------
interface mcd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [1:0]  line_state;
   logic        owner_valid;
   logic [5:0]  owner_host;
   logic [63:0] sharer_mask;
   logic [31:0] line_epoch;
   logic        memory_current;
   logic [31:0] kind_commit_count;

   modport source (output valid, output status, output line_state,
                   output owner_valid, output owner_host, output sharer_mask,
                   output line_epoch, output memory_current,
                   output kind_commit_count, input ready);
   modport sink   (input valid, input status, input line_state,
                   input owner_valid, input owner_host, input sharer_mask,
                   input line_epoch, input memory_current,
                   input kind_commit_count, output ready);
endinterface
`default_nettype wire

[rtl/core/mcd_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mcd_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module mcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic                                        rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                            rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

[rtl/core/mcd_update.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mcd_update
// MESI transition logic: from the current entry, the request kind and the
// host, works out the status, the reported snapshot and the entry to write.
// ----------------------------------------------------------------------------
module mcd_update import mcd_pkg::*; (
   input  wire logic [2:0]        kind,
   input  wire logic [HOST_W-1:0] host,
   input  wire dir_entry_type     cur,
   output      upd_result_type    result
);
   logic [SHARER_W-1:0] host_bit;
   logic [SHARER_W-1:0] owner_bit;
   logic [SHARER_W-1:0] dropped;
   logic                legal;
   logic                has_owner;
   logic                same;
   logic                is_owner;
   dir_entry_type       nx;

   always_comb begin
      host_bit  = SHARER_W'(1) << host;
      owner_bit = SHARER_W'(1) << cur.owner;
      dropped   = cur.sharers & ~host_bit;
      has_owner = (cur.state == ST_E) || (cur.state == ST_M);
      is_owner  = (cur.owner == host);
      nx        = cur;
      legal     = 1'b0;

      case (kind)
         KIND_READ_SHARED: begin
            if (cur.state == ST_I) begin
               nx.state       = ST_E;
               nx.owner       = host;
               nx.sharers     = '0;
               nx.mem_current = 1'b1;
               legal          = 1'b1;
            end else if (cur.state == ST_S) begin
               nx.sharers = cur.sharers | host_bit;
               legal      = 1'b1;
            end else if (cur.state == ST_E && !is_owner) begin
               nx.state       = ST_S;
               nx.owner       = '0;
               nx.sharers     = owner_bit | host_bit;
               nx.mem_current = 1'b1;
               legal          = 1'b1;
            end
         end
         KIND_READ_MODIFY: begin
            if (cur.state == ST_I ||
                (cur.state == ST_S && (cur.sharers & host_bit) == '0) ||
                (cur.state == ST_E && !is_owner)) begin
               nx.state       = ST_M;
               nx.owner       = host;
               nx.sharers     = '0;
               nx.mem_current = 1'b0;
               legal          = 1'b1;
            end
         end
         KIND_UPGRADE: begin
            if (cur.state == ST_E && is_owner) begin
               nx.state       = ST_M;
               nx.mem_current = 1'b0;
               legal          = 1'b1;
            end
         end
         KIND_DROP_SHARED: begin
            if (cur.state == ST_E && is_owner) begin
               nx.state       = ST_I;
               nx.owner       = '0;
               nx.sharers     = '0;
               nx.mem_current = 1'b1;
               legal          = 1'b1;
            end else if (cur.state == ST_S && (cur.sharers & host_bit) != '0) begin
               nx.sharers     = dropped;
               nx.state       = (dropped == '0) ? ST_I : ST_S;
               nx.owner       = '0;
               nx.mem_current = 1'b1;
               legal          = 1'b1;
            end
         end
         KIND_WRITE_BACK: begin
            if (cur.state == ST_M && is_owner) begin
               nx.state       = ST_I;
               nx.owner       = '0;
               nx.sharers     = '0;
               nx.mem_current = 1'b1;
               legal          = 1'b1;
            end
         end
         default: begin
            legal = 1'b0;
         end
      endcase

      // The owner only counts as metadata while the line has one.
      same = (nx.state == cur.state) && (nx.sharers == cur.sharers) &&
             (nx.mem_current == cur.mem_current) &&
             (!has_owner || nx.owner == cur.owner);
      nx.epoch = cur.epoch + EPOCH_W'(1);

      if (!legal) begin
         result.status   = STATUS_BAD_STATE;
         result.snapshot = cur;
         result.commit   = 1'b0;
      end else if (same) begin
         result.status   = STATUS_NO_CHANGE;
         result.snapshot = cur;
         result.commit   = 1'b0;
      end else begin
         result.status   = STATUS_COMMIT;
         result.snapshot = nx;
         result.commit   = 1'b1;
      end
   end
endmodule
`default_nettype wire

[rtl/core/mesi_coherence_directory.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mesi_coherence_directory
// MESI directory over a window of cache lines, one read-modify-write each.
// ----------------------------------------------------------------------------
// Requests arrive on req_if (kind, line byte address, host); one response per
// request leaves on rsp_if with a status and the line's snapshot. A beat is
// taken when valid and ready are both high.
// The directory lives in a single-port-write, registered-read RAM. A request
// is read from the RAM in its accept cycle; once the response register is
// free, it is evaluated, written back and loaded into the response register.
// A new request is taken only once the one before has left the RAM-read
// stage. Only one request is in flight between RAM read and write back, so
// no two accesses to a line overlap.
// The response register decouples the sides: while a response stalls, one
// further request is taken and waits after its RAM read until the response
// register drains.
// After reset a clearing pass writes the idle entry into every line, one per
// cycle, for all LINES (1024) lines; req_if.ready stays low during that pass.
// Per-kind commit counters are cleared at once by reset.
// ----------------------------------------------------------------------------
module mesi_coherence_directory import mcd_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   mcd_req_if.sink    req_if,
   mcd_rsp_if.source  rsp_if
);
   // Clearing pass
   logic             clear_busy_ff, clear_busy_in;
   logic [IDX_W-1:0] clear_idx_ff,  clear_idx_in;

   // Request waiting on RAM read data
   logic              s1_valid_ff, s1_valid_in;
   logic [2:0]        s1_kind_ff;
   logic [HOST_W-1:0] s1_host_ff;
   logic [IDX_W-1:0]  s1_idx_ff;
   logic              s1_unaligned_ff;
   logic              s1_bad_host_ff;

   // Per-kind commit counters
   logic [COUNT_W-1:0] kind_count_ff [NUM_KINDS];

   // Response register
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff;
   dir_entry_type      rsp_entry_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   logic               accept;
   logic               advance;
   logic [IDX_W-1:0]   req_idx;
   logic               req_unaligned;
   logic               req_bad_host;
   logic               kind_known;
   logic [COUNT_W-1:0] cur_count;
   logic [COUNT_W-1:0] next_count;
   dir_entry_type      rd_entry;
   logic [$bits(dir_entry_type)-1:0] rd_bits;
   upd_result_type     upd;
   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   dir_entry_type      ram_wr_data;
   status_type         out_status;
   dir_entry_type      out_entry;
   logic [COUNT_W-1:0] out_count;

   assign req_idx       = IDX_W'(req_if.req_addr >> OFF_W);
   assign req_unaligned = (req_if.req_addr & 16'(LINE_BYTES - 1)) != 16'd0;
   assign req_bad_host  = {1'b0, req_if.requester} >= 9'(HOSTS);

   assign req_if.ready = !clear_busy_ff && !s1_valid_ff;
   assign accept       = req_if.valid && req_if.ready;
   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);

   mcd_ram #(
      .WIDTH ($bits(dir_entry_type)),
      .DEPTH (LINES)
   ) u_dir_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (req_idx),
      .rd_data (rd_bits)
   );

   assign rd_entry = dir_entry_type'(rd_bits);

   mcd_update u_update (
      .kind   (s1_kind_ff),
      .host   (s1_host_ff),
      .cur    (rd_entry),
      .result (upd)
   );

   always_comb begin
      kind_known = s1_kind_ff < 3'(NUM_KINDS);
      cur_count  = kind_known ? kind_count_ff[s1_kind_ff] : '0;
      next_count = cur_count + COUNT_W'(1);

      if (s1_unaligned_ff) begin
         out_status = STATUS_UNALIGNED;
         out_entry  = DIR_IDLE;
         out_count  = cur_count;
      end else if (s1_bad_host_ff) begin
         out_status = STATUS_BAD_HOST;
         out_entry  = DIR_IDLE;
         out_count  = cur_count;
      end else begin
         out_status = upd.status;
         out_entry  = upd.snapshot;
         out_count  = upd.commit ? next_count : cur_count;
      end

      if (clear_busy_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clear_idx_ff;
         ram_wr_data = DIR_IDLE;
      end else begin
         ram_wr_en   = advance && !s1_unaligned_ff && !s1_bad_host_ff && upd.commit;
         ram_wr_addr = s1_idx_ff;
         ram_wr_data = upd.snapshot;
      end

      clear_idx_in  = clear_idx_ff + IDX_W'(1);
      clear_busy_in = clear_busy_ff && (clear_idx_ff != IDX_W'(LINES - 1));

      s1_valid_in  = accept || (s1_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_idx_ff  <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int k = 0; k < NUM_KINDS; k++) begin
            kind_count_ff[k] <= '0;
         end
      end else begin
         clear_busy_ff <= clear_busy_in;
         if (clear_busy_ff) begin
            clear_idx_ff <= clear_idx_in;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ram_wr_en && !clear_busy_ff && kind_known) begin
            kind_count_ff[s1_kind_ff] <= next_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff      <= req_if.req_type;
         s1_host_ff      <= req_if.requester[HOST_W-1:0];
         s1_idx_ff       <= req_idx;
         s1_unaligned_ff <= req_unaligned;
         s1_bad_host_ff  <= req_bad_host;
      end
      if (advance) begin
         rsp_status_ff <= out_status;
         rsp_entry_ff  <= out_entry;
         rsp_count_ff  <= out_count;
      end
   end

   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.status            = rsp_status_ff;
   assign rsp_if.line_state        = rsp_entry_ff.state;
   assign rsp_if.owner_valid       = (rsp_entry_ff.state == ST_E) ||
                                     (rsp_entry_ff.state == ST_M);
   assign rsp_if.owner_host        = rsp_if.owner_valid ? rsp_entry_ff.owner : '0;
   assign rsp_if.sharer_mask       = rsp_entry_ff.sharers;
   assign rsp_if.line_epoch        = rsp_entry_ff.epoch;
   assign rsp_if.memory_current    = rsp_entry_ff.mem_current;
   assign rsp_if.kind_commit_count = rsp_count_ff;
endmodule
`default_nettype wire
